// ===== rtl/midi_track_event_parser_unit_assert.svh =====
// ----------------------------------------------------------------------------
// MIDI track event parser assertion macros
// Clocked on clk, disabled while rst is high.
// ----------------------------------------------------------------------------
`ifndef MIDI_TRACK_EVENT_PARSER_UNIT_ASSERT_SVH
`define MIDI_TRACK_EVENT_PARSER_UNIT_ASSERT_SVH

// same-cycle implication
`define MTEP_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define MTEP_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/mtep_pkg.sv =====
// ----------------------------------------------------------------------------
// MIDI track event parser package
// Field widths, status and event codes, result type, channel event decode.
// ----------------------------------------------------------------------------
package mtep_pkg;

  localparam int KIND_W  = 3;
  localparam int CHAN_W  = 4;
  localparam int KEY_W   = 7;
  localparam int VAL_W   = 14;
  localparam int TEMPO_W = 24;
  localparam int TICK_W  = 32;
  localparam int MODE_W  = 2;

  localparam logic [MODE_W-1:0] MODE_RESET = 2'd1;
  localparam logic [MODE_W-1:0] MODE_OFF   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_ALL   = 2'd1;

  localparam logic [KIND_W-1:0] EV_NONE     = 3'd0;
  localparam logic [KIND_W-1:0] EV_NOTE_OFF = 3'd1;
  localparam logic [KIND_W-1:0] EV_NOTE_ON  = 3'd2;
  localparam logic [KIND_W-1:0] EV_CONTROL  = 3'd3;
  localparam logic [KIND_W-1:0] EV_PROGRAM  = 3'd4;
  localparam logic [KIND_W-1:0] EV_BEND     = 3'd5;
  localparam logic [KIND_W-1:0] EV_TEMPO    = 3'd6;

  localparam logic [7:0] ST_META      = 8'hFF;
  localparam logic [7:0] ST_SYSEX     = 8'hF0;
  localparam logic [7:0] ST_SYSEX_END = 8'hF7;
  localparam logic [7:0] ST_SYSTEM    = 8'hF0;
  localparam logic [7:0] META_TEMPO   = 8'h51;
  localparam logic [7:0] META_EOT     = 8'h2F;

  localparam logic [3:0] HI_NOTE_OFF = 4'h8;
  localparam logic [3:0] HI_NOTE_ON  = 4'h9;
  localparam logic [3:0] HI_CONTROL  = 4'hB;
  localparam logic [3:0] HI_PROGRAM  = 4'hC;
  localparam logic [3:0] HI_PRESSURE = 4'hD;
  localparam logic [3:0] HI_BEND     = 4'hE;

  localparam logic [TEMPO_W-1:0] TEMPO_DEFAULT = 24'd500000;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [CHAN_W-1:0] chan;
    logic [KEY_W-1:0]  key;
    logic [VAL_W-1:0]  val;
  } chan_event_t;

  typedef struct packed {
    logic               valid;
    logic [KIND_W-1:0]  kind;
    logic [CHAN_W-1:0]  chan;
    logic [KEY_W-1:0]   key;
    logic [VAL_W-1:0]   val;
    logic [TEMPO_W-1:0] tempo;
    logic [TICK_W-1:0]  tick;
    logic               finished;
  } result_t;

  function automatic chan_event_t mtep_channel_event(
    input logic              en,
    input logic [7:0]        st,
    input logic [KEY_W-1:0]  a,
    input logic [KEY_W-1:0]  b,
    input logic [MODE_W-1:0] mode
  );
    chan_event_t ev;
    logic        on;
    ev = '0;
    on = mode != MODE_OFF;
    if (en) begin
      case (st[7:4])
        HI_NOTE_OFF: begin
          if (mode == MODE_ALL) begin
            ev.kind = EV_NOTE_OFF;
            ev.key  = a;
          end
        end
        HI_NOTE_ON: begin
          if (mode == MODE_ALL) begin
            ev.key = a;
            if (b == '0) begin
              ev.kind = EV_NOTE_OFF;
            end else begin
              ev.kind = EV_NOTE_ON;
              ev.val  = {7'd0, b};
            end
          end
        end
        HI_CONTROL: begin
          if (on) begin
            ev.kind = EV_CONTROL;
            ev.key  = a;
            ev.val  = {7'd0, b};
          end
        end
        HI_PROGRAM: begin
          if (on) begin
            ev.kind = EV_PROGRAM;
            ev.key  = a;
          end
        end
        HI_BEND: begin
          if (on) begin
            ev.kind = EV_BEND;
            ev.val  = {b, a};
          end
        end
        default: ev = '0;
      endcase
      if (ev.kind != EV_NONE) begin
        ev.chan = st[3:0];
      end
    end
    return ev;
  endfunction

endpackage

// ===== rtl/mtep_if.sv =====
// ----------------------------------------------------------------------------
// MIDI track event parser channels
// Track byte input and event output, valid/ready handshake.
// ----------------------------------------------------------------------------
interface mtep_track_if import mtep_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [7:0] track_byte;
  logic       track_start;
  logic       track_end;

  modport source (output valid, track_byte, track_start, track_end, input ready);
  modport sink   (input valid, track_byte, track_start, track_end, output ready);
endinterface

interface mtep_event_if import mtep_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [KIND_W-1:0]  event_kind;
  logic [CHAN_W-1:0]  channel;
  logic [KEY_W-1:0]   key_or_number;
  logic [VAL_W-1:0]   event_value;
  logic [TEMPO_W-1:0] tempo_us;
  logic [TICK_W-1:0]  event_tick;
  logic               track_finished;

  modport source (output valid, event_kind, channel, key_or_number, event_value,
                  tempo_us, event_tick, track_finished, input ready);
  modport sink   (input valid, event_kind, channel, key_or_number, event_value,
                  tempo_us, event_tick, track_finished, output ready);
endinterface

// ===== rtl/midi_track_event_parser_unit.sv =====
// ----------------------------------------------------------------------------
// MIDI track event parser unit
// Parses one track chunk body a byte at a time and emits decoded events.
//
//   channel     dir  handshake    payload
//   track_in    in   valid/ready  track_byte, track_start, track_end
//   event_out   out  valid/ready  event_kind .. track_finished
//   cfg         in   cfg_write    cfg_data (send_mode)
//
// One byte per cycle; each word is decoded in the cycle it is taken and its
// event lands in the output register on the same edge.
// Input ready drops only while the output register holds an event not taken.
// rst clears the parser and sets send_mode to 1.
// ----------------------------------------------------------------------------
module midi_track_event_parser_unit import mtep_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  mtep_track_if.sink        track_in,
  mtep_event_if.source      event_out,
  input  logic              cfg_write,
  input  logic [MODE_W-1:0] cfg_data
);

  logic [MODE_W-1:0] send_mode;
  logic              take;
  result_t           res;
  result_t           out;
  logic              out_valid;

  assign track_in.ready = !out_valid || event_out.ready;
  assign take           = track_in.valid && track_in.ready;

  mtep_core u_core (
    .clk         (clk),
    .rst         (rst),
    .take        (take),
    .track_byte  (track_in.track_byte),
    .track_start (track_in.track_start),
    .track_end   (track_in.track_end),
    .send_mode   (send_mode),
    .res         (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      send_mode <= MODE_RESET;
    end else if (cfg_write) begin
      send_mode <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take) begin
      out_valid <= res.valid;
    end else if (event_out.ready) begin
      out_valid <= 1'b0;
    end
    if (take && res.valid) begin
      out <= res;
    end
  end

  assign event_out.valid          = out_valid;
  assign event_out.event_kind     = out.kind;
  assign event_out.channel        = out.chan;
  assign event_out.key_or_number  = out.key;
  assign event_out.event_value    = out.val;
  assign event_out.tempo_us       = out.tempo;
  assign event_out.event_tick     = out.tick;
  assign event_out.track_finished = out.finished;

endmodule

// ===== rtl/mtep_core.sv =====
// ----------------------------------------------------------------------------
// MIDI track event parser core
// Parser state and the per-byte decode; the result is taken with the word.
// ----------------------------------------------------------------------------
module mtep_core import mtep_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              take,
  input  logic [7:0]        track_byte,
  input  logic              track_start,
  input  logic              track_end,
  input  logic [MODE_W-1:0] send_mode,
  output result_t           res
);

  typedef enum logic [3:0] {
    PH_DELTA, PH_STATUS, PH_DATA_A, PH_DATA_B, PH_META_TYPE,
    PH_META_LEN, PH_SYSEX_LEN, PH_TEMPO, PH_SKIP
  } phase_t;

  phase_t             phase, phase_next, s_phase;
  logic [27:0]        acc, acc_next, s_acc;
  logic [1:0]         cnt, cnt_next, s_cnt;
  logic [7:0]         running, running_next, s_running;
  logic [7:0]         current, current_next;
  logic [KEY_W-1:0]   first, first_next;
  logic [7:0]         meta, meta_next;
  logic [27:0]        skip, skip_next;
  logic [TEMPO_W-1:0] tempo, tempo_next;
  logic [TICK_W-1:0]  tick, tick_next, s_tick;
  logic               finished, finished_next, s_fin;

  logic [27:0]        v_acc;
  logic               v_done;
  logic [27:0]        skip_dec;
  logic               fin;
  logic               tempo_emit;
  logic               ev_en;
  logic [7:0]         ev_st;
  logic [KEY_W-1:0]   ev_a, ev_b;
  chan_event_t        ce;

  always_comb begin
    s_phase   = track_start ? PH_DELTA : phase;
    s_acc     = track_start ? '0 : acc;
    s_cnt     = track_start ? '0 : cnt;
    s_running = track_start ? '0 : running;
    s_tick    = track_start ? '0 : tick;
    s_fin     = track_start ? 1'b0 : finished;

    v_acc    = {s_acc[20:0], track_byte[6:0]};
    v_done   = !track_byte[7] || (s_cnt == 2'd3);
    skip_dec = (skip != '0) ? skip - 28'd1 : skip;

    phase_next   = s_phase;
    acc_next     = s_acc;
    cnt_next     = s_cnt;
    running_next = s_running;
    current_next = current;
    first_next   = first;
    meta_next    = meta;
    skip_next    = skip;
    tempo_next   = tempo;
    tick_next    = s_tick;
    fin          = 1'b0;
    tempo_emit   = 1'b0;
    ev_en        = 1'b0;
    ev_st        = current;
    ev_a         = first;
    ev_b         = '0;

    if (!s_fin) begin
      case (s_phase)
        PH_DELTA: begin
          if (v_done || track_end) begin
            tick_next = s_tick + {4'd0, v_acc};
          end
          if (v_done) begin
            phase_next = PH_STATUS;
            acc_next   = '0;
            cnt_next   = '0;
          end else begin
            acc_next = v_acc;
            cnt_next = s_cnt + 2'd1;
          end
        end
        PH_STATUS: begin
          acc_next = '0;
          cnt_next = '0;
          if (track_byte[7]) begin
            current_next = track_byte;
            if (track_byte == ST_META) begin
              phase_next = PH_META_TYPE;
            end else if (track_byte == ST_SYSEX || track_byte == ST_SYSEX_END) begin
              phase_next = PH_SYSEX_LEN;
            end else if (track_byte < ST_SYSTEM) begin
              running_next = track_byte;
              phase_next   = PH_DATA_A;
            end else begin
              fin = 1'b1;
            end
          end else if (s_running[7]) begin
            current_next = s_running;
            first_next   = track_byte[6:0];
            if (s_running[7:4] == HI_PROGRAM || s_running[7:4] == HI_PRESSURE) begin
              ev_en      = 1'b1;
              ev_st      = s_running;
              ev_a       = track_byte[6:0];
              phase_next = PH_DELTA;
            end else begin
              phase_next = PH_DATA_B;
            end
          end else begin
            fin = 1'b1;
          end
        end
        PH_DATA_A: begin
          first_next = track_byte[6:0];
          acc_next   = '0;
          cnt_next   = '0;
          if (current[7:4] == HI_PROGRAM || current[7:4] == HI_PRESSURE) begin
            ev_en      = 1'b1;
            ev_a       = track_byte[6:0];
            phase_next = PH_DELTA;
          end else begin
            phase_next = PH_DATA_B;
          end
        end
        PH_DATA_B: begin
          ev_en      = 1'b1;
          ev_b       = track_byte[6:0];
          phase_next = PH_DELTA;
          acc_next   = '0;
          cnt_next   = '0;
        end
        PH_META_TYPE: begin
          meta_next  = track_byte;
          phase_next = PH_META_LEN;
          acc_next   = '0;
          cnt_next   = '0;
        end
        PH_META_LEN, PH_SYSEX_LEN: begin
          acc_next = v_acc;
          cnt_next = s_cnt + 2'd1;
          if (v_done) begin
            if (s_phase == PH_META_LEN && meta == META_EOT) begin
              fin = 1'b1;
            end else begin
              acc_next = '0;
              cnt_next = '0;
              if (s_phase == PH_META_LEN && meta == META_TEMPO && v_acc == 28'd3) begin
                tempo_next = '0;
                phase_next = PH_TEMPO;
              end else if (v_acc == '0) begin
                phase_next = PH_DELTA;
              end else begin
                skip_next  = v_acc;
                phase_next = PH_SKIP;
              end
            end
          end
        end
        PH_TEMPO: begin
          tempo_next = {tempo[15:0], track_byte};
          cnt_next   = s_cnt + 2'd1;
          if (s_cnt == 2'd2) begin
            tempo_emit = 1'b1;
            phase_next = PH_DELTA;
            acc_next   = '0;
            cnt_next   = '0;
          end
        end
        PH_SKIP: begin
          skip_next = skip_dec;
          if (skip_dec == '0) begin
            phase_next = PH_DELTA;
            acc_next   = '0;
            cnt_next   = '0;
          end
        end
        default: begin
          phase_next = PH_DELTA;
          acc_next   = '0;
          cnt_next   = '0;
        end
      endcase

      // last byte: flush a channel event still waiting for data
      if (track_end && !fin) begin
        if (phase_next == PH_DATA_A) begin
          ev_en = 1'b1;
          ev_st = current_next;
          ev_a  = '0;
          ev_b  = '0;
        end else if (phase_next == PH_DATA_B) begin
          ev_en = 1'b1;
          ev_st = current_next;
          ev_a  = first_next;
          ev_b  = '0;
        end
        fin = 1'b1;
      end
    end

    finished_next = s_fin | fin;

    ce = mtep_channel_event(ev_en, ev_st, ev_a, ev_b, send_mode);

    res.kind     = tempo_emit ? EV_TEMPO : ce.kind;
    res.chan     = ce.chan;
    res.key      = ce.key;
    res.val      = ce.val;
    res.tempo    = tempo_emit ? ((tempo_next != '0) ? tempo_next : TEMPO_DEFAULT) : '0;
    res.tick     = tick_next;
    res.finished = fin;
    res.valid    = !s_fin && (tempo_emit || ce.kind != EV_NONE || fin);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase    <= PH_DELTA;
      acc      <= '0;
      cnt      <= '0;
      running  <= '0;
      current  <= '0;
      first    <= '0;
      meta     <= '0;
      skip     <= '0;
      tempo    <= '0;
      tick     <= '0;
      finished <= 1'b0;
    end else if (take) begin
      phase    <= phase_next;
      acc      <= acc_next;
      cnt      <= cnt_next;
      running  <= running_next;
      current  <= current_next;
      first    <= first_next;
      meta     <= meta_next;
      skip     <= skip_next;
      tempo    <= tempo_next;
      tick     <= tick_next;
      finished <= finished_next;
    end
  end

endmodule

// ===== rtl/mtep_checker.sv =====
// ----------------------------------------------------------------------------
// MIDI track event parser checker
// Port-level properties of the parser, bound to the top level.
// ----------------------------------------------------------------------------
`include "midi_track_event_parser_unit_assert.svh"

module mtep_checker import mtep_pkg::*; (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic [KIND_W-1:0]  event_kind,
  input logic [CHAN_W-1:0]  channel,
  input logic [KEY_W-1:0]   key_or_number,
  input logic [VAL_W-1:0]   event_value,
  input logic [TEMPO_W-1:0] tempo_us,
  input logic [TICK_W-1:0]  event_tick,
  input logic               track_finished
);

  `MTEP_ASSERT_NXT(a_out_hold, out_valid && !out_ready,
    out_valid && $stable(event_kind) && $stable(channel) && $stable(key_or_number)
    && $stable(event_value) && $stable(tempo_us) && $stable(event_tick)
    && $stable(track_finished), "event word changed while stalled")

  `MTEP_ASSERT_NOW(a_no_overrun, out_valid && !out_ready, !in_ready,
    "byte taken while event word is stalled")

  `MTEP_ASSERT_NXT(a_no_spurious, !out_valid && !(in_valid && in_ready), !out_valid,
    "event word appeared with no byte taken")

  `MTEP_ASSERT_NOW(a_tempo_only, out_valid,
    (event_kind == EV_TEMPO) == (tempo_us != '0), "tempo field mismatch")

  `MTEP_ASSERT_NOW(a_empty_is_end, out_valid && event_kind == EV_NONE, track_finished,
    "empty event word without track end")

endmodule

bind midi_track_event_parser_unit mtep_checker u_checker (
  .clk            (clk),
  .rst            (rst),
  .in_valid       (track_in.valid),
  .in_ready       (track_in.ready),
  .out_valid      (event_out.valid),
  .out_ready      (event_out.ready),
  .event_kind     (event_out.event_kind),
  .channel        (event_out.channel),
  .key_or_number  (event_out.key_or_number),
  .event_value    (event_out.event_value),
  .tempo_us       (event_out.tempo_us),
  .event_tick     (event_out.event_tick),
  .track_finished (event_out.track_finished)
);

// ===== sim/midi_event_monitor.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// MIDI track event monitor
// Watches the track byte and event channels of the parser, tracks send_mode
// from the config port, predicts the event word each accepted byte produces
// and compares every accepted event word field by field, oldest first.
// ----------------------------------------------------------------------------
module midi_event_monitor import mtep_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  mtep_track_if             trk,
  mtep_event_if             evt,
  input  logic              cfg_write,
  input  logic [MODE_W-1:0] cfg_data,
  output int                errors,
  output int                pending,
  output int                checked
);

  typedef enum logic [3:0] {
    P_DELTA, P_STATUS, P_DATA_A, P_DATA_B, P_META_TYPE, P_META_LEN,
    P_SYSEX_LEN, P_TEMPO, P_SKIP
  } parse_phase_t;

  logic [MODE_W-1:0]  send_mode;
  parse_phase_t       phase;
  logic [31:0]        vlq_acc;
  logic [2:0]         vlq_cnt;
  logic [7:0]         run_status;
  logic [7:0]         cur_status;
  logic [6:0]         first_key;
  logic [7:0]         meta_type;
  logic [31:0]        skip_left;
  logic [TEMPO_W-1:0] tempo_acc;
  logic [TICK_W-1:0]  tick;
  logic               done;
  result_t            next_word;
  result_t            pending_events[$];
  int                 fail_count;
  int                 word_count;

  function automatic void goto_phase(parse_phase_t p);
    phase   = p;
    vlq_acc = '0;
    vlq_cnt = '0;
  endfunction

  function automatic void clear_parser();
    goto_phase(P_DELTA);
    run_status = '0;
    cur_status = '0;
    first_key  = '0;
    meta_type  = '0;
    skip_left  = '0;
    tempo_acc  = '0;
    tick       = '0;
    done       = 1'b0;
  endfunction

  // true when the variable-length number is complete
  function automatic logic vlq_push(logic [7:0] b);
    vlq_acc = {vlq_acc[24:0], b[6:0]};
    vlq_cnt = vlq_cnt + 3'd1;
    return !b[7] || vlq_cnt >= 3'd4;
  endfunction

  function automatic void emit_channel(logic [7:0] st, logic [6:0] a, logic [6:0] b);
    logic              notes_on;
    logic              others_on;
    logic [KIND_W-1:0] kind;
    logic [KEY_W-1:0]  key;
    logic [VAL_W-1:0]  val;
    notes_on  = send_mode == MODE_ALL;
    others_on = send_mode != MODE_OFF;
    kind = EV_NONE;
    key  = '0;
    val  = '0;
    if (st[7:4] == HI_NOTE_OFF || (st[7:4] == HI_NOTE_ON && b == 7'd0)) begin
      if (notes_on) begin
        kind = EV_NOTE_OFF;
        key  = a;
      end
    end else if (st[7:4] == HI_NOTE_ON) begin
      if (notes_on) begin
        kind = EV_NOTE_ON;
        key  = a;
        val  = {7'd0, b};
      end
    end else if (st[7:4] == HI_CONTROL) begin
      if (others_on) begin
        kind = EV_CONTROL;
        key  = a;
        val  = {7'd0, b};
      end
    end else if (st[7:4] == HI_PROGRAM) begin
      if (others_on) begin
        kind = EV_PROGRAM;
        key  = a;
      end
    end else if (st[7:4] == HI_BEND) begin
      if (others_on) begin
        kind = EV_BEND;
        val  = {b, a};
      end
    end
    if (kind != EV_NONE) begin
      next_word.kind = kind;
      next_word.chan = st[3:0];
      next_word.key  = key;
      next_word.val  = val;
    end
  endfunction

  function automatic void take_first_key(logic [6:0] a);
    first_key = a;
    if (cur_status[7:4] == HI_PROGRAM || cur_status[7:4] == HI_PRESSURE) begin
      emit_channel(cur_status, a, 7'd0);
      goto_phase(P_DELTA);
    end else begin
      goto_phase(P_DATA_B);
    end
  endfunction

  // returns 1 when the byte yields an event word, left in next_word
  function automatic logic parse_track_byte(logic [7:0] b, logic first, logic last);
    logic        fin;
    logic [31:0] len;
    logic        is_meta;
    if (first) begin
      clear_parser();
    end
    if (done) begin
      return 1'b0;
    end
    fin       = 1'b0;
    next_word = '0;
    case (phase)
      P_DELTA: begin
        if (vlq_push(b)) begin
          tick = tick + vlq_acc;
          goto_phase(P_STATUS);
        end
      end
      P_STATUS: begin
        if (b[7]) begin
          cur_status = b;
          if (b == ST_META) begin
            goto_phase(P_META_TYPE);
          end else if (b == ST_SYSEX || b == ST_SYSEX_END) begin
            goto_phase(P_SYSEX_LEN);
          end else if (b < ST_SYSTEM) begin
            run_status = b;
            goto_phase(P_DATA_A);
          end else begin
            fin = 1'b1;
          end
        end else if (run_status[7]) begin
          cur_status = run_status;
          take_first_key(b[6:0]);
        end else begin
          fin = 1'b1;
        end
      end
      P_DATA_A: take_first_key(b[6:0]);
      P_DATA_B: begin
        emit_channel(cur_status, first_key, b[6:0]);
        goto_phase(P_DELTA);
      end
      P_META_TYPE: begin
        meta_type = b;
        goto_phase(P_META_LEN);
      end
      P_META_LEN, P_SYSEX_LEN: begin
        if (vlq_push(b)) begin
          len     = vlq_acc;
          is_meta = phase == P_META_LEN;
          if (is_meta && meta_type == META_EOT) begin
            fin = 1'b1;
          end else if (is_meta && meta_type == META_TEMPO && len == 32'd3) begin
            tempo_acc = '0;
            goto_phase(P_TEMPO);
          end else if (len == 32'd0) begin
            goto_phase(P_DELTA);
          end else begin
            skip_left = len;
            goto_phase(P_SKIP);
          end
        end
      end
      P_TEMPO: begin
        tempo_acc = {tempo_acc[15:0], b};
        vlq_cnt   = vlq_cnt + 3'd1;
        if (vlq_cnt >= 3'd3) begin
          next_word.kind  = EV_TEMPO;
          next_word.tempo = (tempo_acc != '0) ? tempo_acc : TEMPO_DEFAULT;
          goto_phase(P_DELTA);
        end
      end
      P_SKIP: begin
        if (skip_left != '0) begin
          skip_left = skip_left - 32'd1;
        end
        if (skip_left == '0) begin
          goto_phase(P_DELTA);
        end
      end
      default: goto_phase(P_DELTA);
    endcase
    // last byte of the chunk: flush a short channel event or partial delta
    if (last && !fin) begin
      case (phase)
        P_DATA_A: emit_channel(cur_status, 7'd0, 7'd0);
        P_DATA_B: emit_channel(cur_status, first_key, 7'd0);
        P_DELTA:  tick = tick + vlq_acc;
        default:  ;
      endcase
      fin = 1'b1;
    end
    if (fin) begin
      done = 1'b1;
    end
    next_word.tick     = tick;
    next_word.finished = fin;
    return next_word.kind != EV_NONE || fin;
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] seen);
    if (want !== seen) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, seen);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      send_mode = MODE_RESET;
      clear_parser();
      pending_events.delete();
    end else begin
      if (cfg_write) begin
        send_mode = cfg_data;
      end
      if (evt.valid && evt.ready) begin
        if (pending_events.size() == 0) begin
          $error("event word kind %0d tick %0d arrived with none predicted",
                 evt.event_kind, evt.event_tick);
          fail_count++;
        end else begin
          want = pending_events.pop_front();
          check_field("event_kind", 32'(want.kind), 32'(evt.event_kind));
          check_field("channel", 32'(want.chan), 32'(evt.channel));
          check_field("key_or_number", 32'(want.key), 32'(evt.key_or_number));
          check_field("event_value", 32'(want.val), 32'(evt.event_value));
          check_field("tempo_us", 32'(want.tempo), 32'(evt.tempo_us));
          check_field("event_tick", want.tick, evt.event_tick);
          check_field("track_finished", 32'(want.finished), 32'(evt.track_finished));
          word_count++;
        end
      end
      if (trk.valid && trk.ready) begin
        if (parse_track_byte(trk.track_byte, trk.track_start, trk.track_end)) begin
          pending_events.push_back(next_word);
        end
      end
    end
    pending <= pending_events.size();
    errors  <= fail_count;
    checked <= word_count;
  end

endmodule

// ===== sim/midi_track_event_parser_unit_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// MIDI track event parser unit test
// Feeds directed and random track chunks (well-formed event streams, running
// status, meta, sysex, tempo, truncation, unknown status, noise) through the
// parser under every send_mode, with random gaps and stalls on both channels.
// The monitor predicts and checks the event words; this module gives the verdict.
// ----------------------------------------------------------------------------
module midi_track_event_parser_unit_test;
  import mtep_pkg::*;

  localparam int IDLE_LIMIT   = 600;
  localparam int RANDOM_BYTES = 1100;
  localparam int PHASE_BYTES  = 140;

  logic              clk;
  logic              rst;
  logic              cfg_write;
  logic [MODE_W-1:0] cfg_data;

  mtep_track_if trk();
  mtep_event_if evt();

  int          errors;
  int          pending;
  int          checked;
  int          idle_cycles;
  int          bytes_sent;
  int          tracks_sent;
  int          phases_run;
  bit          calm;
  bit          huge;
  bit          mark_end;
  bit          have_running;
  logic [7:0]  last_status;
  logic [7:0]  trk_q[$];

  midi_track_event_parser_unit dut (
    .clk       (clk),
    .rst       (rst),
    .track_in  (trk),
    .event_out (evt),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data)
  );

  midi_event_monitor event_mon (
    .clk       (clk),
    .rst       (rst),
    .trk       (trk),
    .evt       (evt),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data),
    .errors    (errors),
    .pending   (pending),
    .checked   (checked)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst || (trk.valid && trk.ready) || (evt.valid && evt.ready) || cfg_write) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("watchdog: no word moved for %0d cycles", IDLE_LIMIT);
      $display("Some tests failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // event sink with random stalls
  initial begin
    int stall;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      stall = calm ? 0 : $urandom_range(0, 16);
      if (stall != 0) begin
        evt.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      evt.ready <= 1'b1;
      @(posedge clk);
      while (!evt.valid) @(posedge clk);
    end
  end

  function automatic logic [7:0] data_byte();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r == 0) return 8'($urandom_range(128, 255));
    if (r == 1) return 8'h00;
    if (r == 2) return 8'h7F;
    return 8'($urandom_range(0, 127));
  endfunction

  function automatic void put_delta();
    int unsigned sel;
    int unsigned n;
    sel = $urandom_range(0, 19);
    if (huge || sel == 19) begin
      trk_q.push_back(8'hFF);
      trk_q.push_back(8'hFF);
      trk_q.push_back(8'hFF);
      trk_q.push_back(8'h7F);
      return;
    end
    n = sel < 12 ? 1 : sel < 16 ? 2 : sel < 17 ? 3 : 4;
    for (int k = 1; k < n; k++) trk_q.push_back({1'b1, 7'($urandom_range(0, 127))});
    // sel 18: fourth byte still flags more
    trk_q.push_back({sel == 18, 7'(sel < 4 ? 0 : $urandom_range(0, 127))});
  endfunction

  function automatic void put_channel_data(logic [7:0] st, logic running);
    if (running) trk_q.push_back(data_byte() & 8'h7F);
    else trk_q.push_back(data_byte());
    if (st[7:4] != HI_PROGRAM && st[7:4] != HI_PRESSURE) begin
      if (st[7:4] == HI_NOTE_ON && $urandom_range(0, 3) == 0) trk_q.push_back(8'h00);
      else trk_q.push_back(data_byte());
    end
  endfunction

  function automatic void put_event();
    int unsigned sel;
    int unsigned len;
    logic [7:0]  st;
    logic [7:0]  mtype;
    sel = $urandom_range(0, 99);
    if (sel < 45 || (sel < 60 && !have_running)) begin
      st = {4'($urandom_range(8, 14)), 4'($urandom_range(0, 15))};
      trk_q.push_back(st);
      have_running = 1'b1;
      last_status  = st;
      put_channel_data(st, 1'b0);
    end else if (sel < 60) begin
      put_channel_data(last_status, 1'b1);
    end else if (sel < 72) begin
      trk_q.push_back(ST_META);
      trk_q.push_back(META_TEMPO);
      trk_q.push_back(8'h03);
      if ($urandom_range(0, 3) == 0) repeat (3) trk_q.push_back(8'h00);
      else repeat (3) trk_q.push_back(8'($urandom_range(0, 255)));
    end else if (sel < 82) begin
      mtype = 8'($urandom_range(0, 127));
      if (mtype == META_EOT) mtype = META_TEMPO;
      len = $urandom_range(0, 6);
      trk_q.push_back(ST_META);
      trk_q.push_back(mtype);
      trk_q.push_back(8'(len));
      repeat (len) trk_q.push_back(8'($urandom_range(0, 255)));
    end else if (sel < 94) begin
      len = $urandom_range(0, 6);
      trk_q.push_back($urandom_range(0, 1) ? ST_SYSEX : ST_SYSEX_END);
      if ($urandom_range(0, 4) == 0) trk_q.push_back(8'h80);
      trk_q.push_back(8'(len));
      repeat (len) trk_q.push_back(8'($urandom_range(0, 255)));
    end else if (sel < 97 || have_running) begin
      st = 8'($urandom_range(8'hF1, 8'hFE));
      if (st == ST_SYSEX_END) st = 8'hF4;
      trk_q.push_back(st);
    end else begin
      // data byte with no channel status seen yet
      trk_q.push_back(8'($urandom_range(0, 127)));
    end
  endfunction

  function automatic void build_track();
    int unsigned shape;
    int unsigned n_events;
    trk_q.delete();
    have_running = 1'b0;
    last_status  = '0;
    huge         = 1'b0;
    mark_end     = 1'b1;
    shape = $urandom_range(0, 19);
    if (shape < 2) begin
      repeat ($urandom_range(1, 20)) trk_q.push_back(8'($urandom_range(0, 255)));
      return;
    end
    huge     = shape == 2;
    n_events = huge ? 18 : $urandom_range(2, 12);
    repeat (n_events) begin
      put_delta();
      put_event();
    end
    if ($urandom_range(0, 4) != 0) begin
      put_delta();
      trk_q.push_back(ST_META);
      trk_q.push_back(META_EOT);
      trk_q.push_back(8'h00);
      repeat ($urandom_range(0, 2)) trk_q.push_back(8'($urandom_range(0, 255)));
    end
    if ($urandom_range(0, 6) == 0) begin
      repeat ($urandom_range(1, 4)) if (trk_q.size() > 1) void'(trk_q.pop_back());
    end
    mark_end = $urandom_range(0, 9) != 0;
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic first, input logic last);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 16);
    if (gap != 0) begin
      trk.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    trk.valid       <= 1'b1;
    trk.track_byte  <= b;
    trk.track_start <= first;
    trk.track_end   <= last;
    @(posedge clk);
    while (!trk.ready) @(posedge clk);
    bytes_sent++;
  endtask

  task automatic send_track();
    for (int i = 0; i < trk_q.size(); i++) begin
      send_byte(trk_q[i], i == 0, mark_end && i == trk_q.size() - 1);
    end
    tracks_sent++;
  endtask

  task automatic settle();
    trk.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_mode(input logic [MODE_W-1:0] m);
    cfg_write <= 1'b1;
    cfg_data  <= m;
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  initial begin
    logic [MODE_W-1:0] mode_plan[8];
    int                random_base;
    mode_plan = '{2'd0, 2'd2, 2'd3, 2'd1, 2'd2, 2'd0, 2'd1, 2'd3};
    rst             <= 1'b1;
    cfg_write       <= 1'b0;
    cfg_data        <= '0;
    trk.valid       <= 1'b0;
    trk.track_byte  <= '0;
    trk.track_start <= 1'b0;
    trk.track_end   <= 1'b0;
    evt.ready       <= 1'b0;
    calm            = 1'b0;
    mark_end        = 1'b1;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // note on, running-status note on at velocity 0, long delta, bend with
    // high-bit data, zero tempo, unknown status
    trk_q = '{8'h00, 8'h90, 8'h7F, 8'h64, 8'h7F, 8'h3C, 8'h00,
              8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hE5, 8'hFF, 8'hFF,
              8'h00, 8'hFF, 8'h51, 8'h03, 8'h00, 8'h00, 8'h00,
              8'h00, 8'hF5};
    send_track();
    // one-byte track ending inside a delta
    trk_q = '{8'h85};
    send_track();
    // control change cut short by the last byte
    trk_q = '{8'h00, 8'hB3, 8'h07};
    send_track();

    random_base = bytes_sent;
    while (bytes_sent - random_base < RANDOM_BYTES) begin
      settle();
      write_mode(mode_plan[phases_run % 8]);
      calm = phases_run % 4 == 3;
      phases_run++;
      while (bytes_sent - random_base < phases_run * PHASE_BYTES &&
             bytes_sent - random_base < RANDOM_BYTES) begin
        build_track();
        send_track();
      end
    end
    calm = 1'b0;
    settle();

    $display("Sent %0d track bytes in %0d tracks over %0d send_mode phases (0 to 3).",
             bytes_sent, tracks_sent, phases_run);
    $display("Checked %0d event words, %0d mismatches.", checked, errors);
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
